/* src/player_slot_table_core_assert.svh */
// Assertion macros for the player slot table core.
// Expects clk and rst in the scope of each use.
`ifndef PLAYER_SLOT_TABLE_CORE_ASSERT_SVH
`define PLAYER_SLOT_TABLE_CORE_ASSERT_SVH

// Same-cycle implication.
`define PST_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("player slot table check failed");

// Next-cycle implication.
`define PST_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("player slot table check failed");

`endif

/* src/pst_pkg.sv */
// Shared types and constants for the player slot table.
// No dependencies.
`timescale 1ns / 1ps
package pst_pkg;

  localparam int SLOTS = 16;
  localparam int IDX_W = $clog2(SLOTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  localparam int SLOT_OUT_W = 4;
  localparam int NET_W = 64;
  localparam int PID_W = 16;
  localparam int COL_W = 24;
  localparam int ID_W = 15;

  localparam logic [ID_W-1:0] ID_MAX = '1;
  localparam logic [ID_W-1:0] ID_FIRST = ID_W'(1);
  localparam logic [COL_W-1:0] WHITE = '1;
  localparam logic signed [PID_W-1:0] PID_NONE = -16'sd1;

  typedef enum logic [2:0] {
    ACT_RESET      = 3'd0,
    ACT_ADD        = 3'd1,
    ACT_REMOVE     = 3'd2,
    ACT_MARK       = 3'd3,
    ACT_FIND_NET   = 3'd4,
    ACT_FIND_PID   = 3'd5,
    ACT_ALLOC      = 3'd6,
    ACT_SET_LOCAL  = 3'd7
  } action_t;

  typedef enum logic [1:0] {
    ST_UNUSED = 2'd0,
    ST_ACTIVE = 2'd1,
    ST_DISC   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    M_UNUSED     = 2'd0,
    M_ACTIVE_NET = 2'd1,
    M_ACTIVE_PID = 2'd2,
    M_USED_PID   = 2'd3
  } match_mode_t;

  typedef enum logic [2:0] {
    WR_NONE   = 3'd0,
    WR_CLEAR  = 3'd1,
    WR_ADD    = 3'd2,
    WR_STATUS = 3'd3,
    WR_LOCAL  = 3'd4
  } wr_op_t;

  typedef struct packed {
    status_t           status;
    logic [NET_W-1:0]  net;
    logic [PID_W-1:0]  pid;
    logic [COL_W-1:0]  colour;
  } entry_t;

  typedef struct packed {
    wr_op_t            op;
    logic [IDX_W-1:0]  idx;
    status_t           status;
    logic [NET_W-1:0]  net;
    logic [PID_W-1:0]  pid;
    logic [COL_W-1:0]  colour;
    logic              reset_all;
    logic              reset_local_id;
  } wr_cmd_t;

endpackage

/* src/pst_req_if.sv */
// Request channel of the player slot table: valid/ready plus one request beat.
// No dependencies.
`timescale 1ns / 1ps
interface pst_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         action;
  logic [63:0]        network_id;
  logic signed [15:0] player_id;
  logic [7:0]         red;
  logic [7:0]         green;
  logic [7:0]         blue;
  logic               reset_all;
  logic               reset_local_id;

  modport source (
    output valid, action, network_id, player_id, red, green, blue,
           reset_all, reset_local_id,
    input  ready
  );
  modport sink (
    input  valid, action, network_id, player_id, red, green, blue,
           reset_all, reset_local_id,
    output ready
  );
endinterface

/* src/pst_rsp_if.sv */
// Response channel of the player slot table: valid/ready plus one result beat.
// No dependencies.
`timescale 1ns / 1ps
interface pst_rsp_if;
  logic               valid;
  logic               ready;
  logic               ok;
  logic [3:0]         slot;
  logic [63:0]        entry_network_id;
  logic signed [15:0] entry_player_id;
  logic [7:0]         entry_red;
  logic [7:0]         entry_green;
  logic [7:0]         entry_blue;

  modport source (
    output valid, ok, slot, entry_network_id, entry_player_id, entry_red,
           entry_green, entry_blue,
    input  ready
  );
  modport sink (
    input  valid, ok, slot, entry_network_id, entry_player_id, entry_red,
           entry_green, entry_blue,
    output ready
  );
endinterface

/* src/pst_match.sv */
// Shared compare unit: tests one table entry against the current search key.
// Depends on pst_pkg.
`timescale 1ns / 1ps
module pst_match import pst_pkg::*; (
  input  match_mode_t        mode,
  input  entry_t             entry,
  input  logic [NET_W-1:0]   key_net,
  input  logic [PID_W-1:0]   key_pid,
  output logic               hit
);

  always_comb begin
    unique case (mode)
      M_UNUSED:     hit = (entry.status == ST_UNUSED);
      M_ACTIVE_NET: hit = (entry.status == ST_ACTIVE) && (entry.net == key_net);
      M_ACTIVE_PID: hit = (entry.status == ST_ACTIVE) && (entry.pid == key_pid);
      M_USED_PID:   hit = (entry.status != ST_UNUSED) && (entry.pid == key_pid);
      default:      hit = 1'b0;
    endcase
  end

endmodule

/* src/pst_table.sv */
// Slot storage: status, network id, player id and colour per slot.
// One indexed read port, one write command per cycle. Depends on pst_pkg.
`timescale 1ns / 1ps
module pst_table import pst_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [IDX_W-1:0]  rd_idx,
  input  wr_cmd_t           wr,
  output entry_t            rd
);

  status_t           status [SLOTS];
  logic [NET_W-1:0]  net    [SLOTS];
  logic [PID_W-1:0]  pid    [SLOTS];
  logic [COL_W-1:0]  colour [SLOTS];

  assign rd = '{status: status[rd_idx], net: net[rd_idx], pid: pid[rd_idx],
                colour: colour[rd_idx]};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        status[i] <= (i == 0) ? ST_ACTIVE : ST_UNUSED;
      end
      net[0]    <= '0;
      pid[0]    <= '0;
      colour[0] <= WHITE;
    end else begin
      unique case (wr.op)
        WR_NONE: ;
        WR_CLEAR: begin
          for (int i = 0; i < SLOTS; i++) begin
            status[i] <= (i == 0) ? ST_ACTIVE : ST_UNUSED;
          end
          if (wr.reset_all) begin
            net[0]    <= '0;
            colour[0] <= WHITE;
          end
          if (wr.reset_local_id) begin
            pid[0] <= '0;
          end
        end
        WR_ADD: begin
          status[wr.idx] <= ST_ACTIVE;
          net[wr.idx]    <= wr.net;
          pid[wr.idx]    <= wr.pid;
          colour[wr.idx] <= wr.colour;
        end
        WR_STATUS: status[wr.idx] <= wr.status;
        WR_LOCAL:  pid[0] <= wr.pid;
        default: ;
      endcase
    end
  end

endmodule

/* src/player_slot_table_core.sv */
// Player slot table top level: request sequencer, slot scan and result register.
// Depends on pst_pkg, pst_req_if, pst_rsp_if, pst_match, pst_table and the
// assertion macro header.
//
// Usage:
//   req carries one action beat (reset, add, remove, mark disconnected, find by
//   network id, find by player id, allocate id, set local id); rsp returns
//   exactly one result beat for every request. Both channels move a beat when
//   valid and ready are high at a rising edge of clk.
//   One request is in flight at a time: req.ready is high only while the block
//   is idle, and drops from the accept until the result beat is taken.
//   Reset and set local id write the table at the accept and go straight to the
//   result state. Add, remove, mark and both finds walk the slots through one
//   compare unit, one slot a cycle, until the first hit or the last slot.
//   Allocate takes each candidate id in turn and scans the slots for it, one slot
//   a cycle, stopping early on a clash and moving on to the next candidate.
//   The result waits in its register while rsp.ready is low; nothing else
//   moves until it is taken.
//   rst (synchronous, active high) leaves slot 0 active with network id 0,
//   player id 0 and white colour, all other slots unused, and the allocator
//   counter at zero.
`timescale 1ns / 1ps
`include "player_slot_table_core_assert.svh"
module player_slot_table_core import pst_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  pst_req_if.sink   req,
  pst_rsp_if.source rsp
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CAND,
    S_SCAN,
    S_OUT
  } state_t;

  state_t             state;
  action_t            act;
  match_mode_t        mode;
  logic [IDX_W-1:0]   scan_idx;
  logic [NET_W-1:0]   key_net;
  logic [PID_W-1:0]   key_pid;
  logic [COL_W-1:0]   req_colour;
  logic [ID_W-1:0]    last_id;
  logic [ID_W-1:0]    start_id;
  logic [ID_W-1:0]    cand;

  logic               o_ok;
  logic [SLOT_OUT_W-1:0] o_slot;
  logic [NET_W-1:0]   o_net;
  logic [PID_W-1:0]   o_pid;
  logic [COL_W-1:0]   o_colour;

  entry_t             rd;
  wr_cmd_t            wr;
  logic               hit;
  logic               accept;

  pst_table u_table (
    .clk    (clk),
    .rst    (rst),
    .rd_idx (scan_idx),
    .wr     (wr),
    .rd     (rd)
  );

  pst_match u_match (
    .mode    (mode),
    .entry   (rd),
    .key_net (key_net),
    .key_pid (key_pid),
    .hit     (hit)
  );

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign cand      = (last_id == ID_MAX) ? ID_FIRST : last_id + ID_FIRST;

  assign rsp.valid            = (state == S_OUT);
  assign rsp.ok               = o_ok;
  assign rsp.slot             = o_slot;
  assign rsp.entry_network_id = o_net;
  assign rsp.entry_player_id  = o_pid;
  assign rsp.entry_red        = o_colour[23:16];
  assign rsp.entry_green      = o_colour[15:8];
  assign rsp.entry_blue       = o_colour[7:0];

  // Table write command.
  always_comb begin
    wr                = '0;
    wr.op             = WR_NONE;
    wr.idx            = scan_idx;
    wr.status         = ST_UNUSED;
    wr.net            = key_net;
    wr.pid            = key_pid;
    wr.colour         = req_colour;
    wr.reset_all      = req.reset_all;
    wr.reset_local_id = req.reset_local_id;
    if (accept && action_t'(req.action) == ACT_RESET) begin
      wr.op = WR_CLEAR;
    end else if (accept && action_t'(req.action) == ACT_SET_LOCAL) begin
      wr.op  = WR_LOCAL;
      wr.pid = req.player_id;
    end else if (state == S_SCAN && hit) begin
      unique case (act)
        ACT_ADD: wr.op = WR_ADD;
        ACT_REMOVE: begin
          wr.op     = WR_STATUS;
          wr.status = ST_UNUSED;
        end
        ACT_MARK: begin
          wr.op     = WR_STATUS;
          wr.status = ST_DISC;
        end
        default: wr.op = WR_NONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      last_id  <= '0;
      scan_idx <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            act        <= action_t'(req.action);
            key_net    <= req.network_id;
            key_pid    <= req.player_id;
            req_colour <= {req.red, req.green, req.blue};
            scan_idx   <= '0;
            o_ok       <= 1'b0;
            o_slot     <= '0;
            o_net      <= '0;
            o_pid      <= '0;
            o_colour   <= '0;
            unique case (action_t'(req.action))
              ACT_RESET: begin
                last_id <= '0;
                state   <= S_OUT;
              end
              ACT_SET_LOCAL: state <= S_OUT;
              ACT_ADD: begin
                mode  <= M_UNUSED;
                state <= S_SCAN;
              end
              ACT_REMOVE, ACT_MARK, ACT_FIND_NET: begin
                mode  <= M_ACTIVE_NET;
                state <= S_SCAN;
              end
              ACT_FIND_PID: begin
                mode  <= M_ACTIVE_PID;
                state <= S_SCAN;
              end
              ACT_ALLOC: begin
                mode     <= M_USED_PID;
                start_id <= last_id;
                state    <= S_CAND;
              end
              default: state <= S_OUT;
            endcase
          end
        end
        S_CAND: begin
          last_id  <= cand;
          scan_idx <= '0;
          if (cand == start_id) begin
            o_pid <= PID_NONE;
            state <= S_OUT;
          end else begin
            key_pid <= {1'b0, cand};
            state   <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (hit && act == ACT_ALLOC) begin
            state <= S_CAND;
          end else if (hit) begin
            o_ok   <= 1'b1;
            o_slot <= SLOT_OUT_W'(scan_idx);
            if (act == ACT_ADD) begin
              o_net    <= key_net;
              o_pid    <= key_pid;
              o_colour <= req_colour;
            end else begin
              o_net    <= rd.net;
              o_pid    <= rd.pid;
              o_colour <= rd.colour;
            end
            state <= S_OUT;
          end else if (scan_idx == LAST_IDX) begin
            if (act == ACT_ALLOC) begin
              o_ok  <= 1'b1;
              o_pid <= key_pid;
            end
            state <= S_OUT;
          end else begin
            scan_idx <= scan_idx + IDX_W'(1);
          end
        end
        S_OUT: begin
          if (rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `PST_ASSERT_NOW(a_ready_excl_valid, req.ready, !rsp.valid)
  `PST_ASSERT_NEXT(a_busy_after_accept, accept, !req.ready)
  `PST_ASSERT_NOW(a_miss_is_clean, rsp.valid && !rsp.ok,
                  rsp.slot == '0 && rsp.entry_network_id == '0 && rsp.entry_red == '0)
  `PST_ASSERT_NOW(a_scan_in_range, state == S_SCAN, scan_idx <= LAST_IDX)

endmodule

/* bench/testbench.sv */
// Self-checking bench for player_slot_table_core: queued request beats, a predictor of the
// slot table, and a response monitor. Depends on pst_pkg, pst_req_if, pst_rsp_if and the core.
`timescale 1ns / 1ps
module testbench;
  import pst_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 320;
  localparam int PHASE_ITEMS = 610;

  typedef struct packed {
    action_t            act;
    logic [63:0]        net;
    logic signed [15:0] pid;
    logic [23:0]        colour;
    logic               all;
    logic               loc;
  } slot_req_t;

  typedef struct packed {
    logic               ok;
    logic [3:0]         slot;
    logic [63:0]        net;
    logic signed [15:0] pid;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
  } slot_result_t;

  logic clk = 1'b0;
  logic rst;

  pst_req_if req();
  pst_rsp_if rsp();

  player_slot_table_core dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  always #4 clk = ~clk;

  status_t            tbl_status [SLOTS];
  logic [63:0]        tbl_net    [SLOTS];
  logic signed [15:0] tbl_pid    [SLOTS];
  logic [23:0]        tbl_colour [SLOTS];
  logic [ID_W-1:0]    alloc_cursor;

  slot_req_t    req_backlog[$];
  slot_result_t expected_results[$];
  slot_req_t    beat_cur;
  logic [63:0]  net_pool [8];
  int src_idle_pct;
  int sink_idle_pct;
  int mismatch_count;
  int queued;
  int quiet_cycles;

  function automatic void clear_table(logic all, logic loc);
    for (int i = 1; i < SLOTS; i++) begin
      tbl_status[i] = ST_UNUSED;
      tbl_net[i] = '0;
      tbl_pid[i] = '0;
      tbl_colour[i] = WHITE;
    end
    tbl_status[0] = ST_ACTIVE;
    alloc_cursor = '0;
    if (all) begin
      tbl_net[0] = '0;
      tbl_colour[0] = WHITE;
    end
    if (loc) tbl_pid[0] = '0;
  endfunction

  function automatic slot_result_t run_table_action(slot_req_t b);
    slot_result_t res;
    int hit;
    logic [ID_W-1:0] start;
    logic [ID_W-1:0] cand;
    bit held;
    res = '0;
    hit = -1;
    case (b.act)
      ACT_RESET: clear_table(b.all, b.loc);
      ACT_ADD: begin
        for (int i = 0; i < SLOTS; i++)
          if (hit < 0 && tbl_status[i] == ST_UNUSED) hit = i;
        if (hit >= 0) begin
          tbl_status[hit] = ST_ACTIVE;
          tbl_net[hit] = b.net;
          tbl_pid[hit] = b.pid;
          tbl_colour[hit] = b.colour;
        end
      end
      ACT_REMOVE, ACT_MARK, ACT_FIND_NET: begin
        for (int i = 0; i < SLOTS; i++)
          if (hit < 0 && tbl_status[i] == ST_ACTIVE && tbl_net[i] == b.net) hit = i;
        if (hit >= 0 && b.act == ACT_REMOVE) tbl_status[hit] = ST_UNUSED;
        if (hit >= 0 && b.act == ACT_MARK) tbl_status[hit] = ST_DISC;
      end
      ACT_FIND_PID: begin
        for (int i = 0; i < SLOTS; i++)
          if (hit < 0 && tbl_status[i] == ST_ACTIVE && tbl_pid[i] == b.pid) hit = i;
      end
      ACT_ALLOC: begin
        res.pid = PID_NONE;
        start = alloc_cursor;
        for (int t = 0; t <= 32767; t++) begin
          cand = (alloc_cursor == ID_MAX) ? ID_FIRST : alloc_cursor + ID_FIRST;
          alloc_cursor = cand;
          if (cand == start) break;
          held = 1'b0;
          for (int i = 0; i < SLOTS; i++)
            if (tbl_status[i] != ST_UNUSED && tbl_pid[i] == {1'b0, cand}) held = 1'b1;
          if (!held) begin
            res.ok = 1'b1;
            res.pid = {1'b0, cand};
            break;
          end
        end
      end
      default: tbl_pid[0] = b.pid;
    endcase
    if (hit >= 0) begin
      res.ok = 1'b1;
      res.slot = 4'(hit);
      res.net = tbl_net[hit];
      res.pid = tbl_pid[hit];
      {res.red, res.green, res.blue} = tbl_colour[hit];
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch %s: got %h, want %h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic push_beat(action_t a, logic [63:0] n, logic signed [15:0] p,
                           logic [23:0] c, logic all, logic loc);
    slot_req_t b;
    b.act = a;
    b.net = n;
    b.pid = p;
    b.colour = c;
    b.all = all;
    b.loc = loc;
    req_backlog.push_back(b);
    queued++;
  endtask

  function automatic logic [63:0] pick_net();
    if ($urandom_range(7) != 0) return net_pool[3'($urandom_range(7))];
    return {$urandom, $urandom};
  endfunction

  function automatic logic signed [15:0] pick_pid();
    logic signed [15:0] v;
    if ($urandom_range(3) == 0) return 16'($urandom);
    v = 16'($urandom_range(10));
    return v - 16'sd2;
  endfunction

  task automatic push_noise();
    push_beat(action_t'($urandom_range(7)), {$urandom, $urandom}, 16'($urandom),
              24'($urandom), 1'($urandom), 1'($urandom));
  endtask

  task automatic push_sane_op();
    int pick;
    pick = $urandom_range(15);
    if (pick <= 4)
      push_beat(ACT_ADD, pick_net(), pick_pid(), 24'($urandom), 1'($urandom), 1'($urandom));
    else if (pick <= 6)
      push_beat(ACT_REMOVE, pick_net(), pick_pid(), 24'($urandom), 1'($urandom), 1'($urandom));
    else if (pick == 7)
      push_beat(ACT_MARK, pick_net(), pick_pid(), 24'($urandom), 1'($urandom), 1'($urandom));
    else if (pick <= 9)
      push_beat(ACT_FIND_NET, pick_net(), pick_pid(), 24'($urandom), 1'($urandom), 1'($urandom));
    else if (pick <= 11)
      push_beat(ACT_FIND_PID, pick_net(), pick_pid(), 24'($urandom), 1'($urandom), 1'($urandom));
    else if (pick <= 13)
      push_beat(ACT_ALLOC, pick_net(), pick_pid(), 24'($urandom), 1'($urandom), 1'($urandom));
    else if (pick == 14)
      push_beat(ACT_SET_LOCAL, pick_net(), pick_pid(), 24'($urandom), 1'($urandom),
                1'($urandom));
    else
      push_beat(ACT_RESET, pick_net(), pick_pid(), 24'($urandom), 1'($urandom), 1'($urandom));
  endtask

  task automatic run_phase(int src_pct, int sink_pct);
    int target;
    int sel;
    int n;
    src_idle_pct = src_pct;
    sink_idle_pct = sink_pct;
    target = queued + PHASE_ITEMS;
    while (queued < target) begin
      sel = $urandom_range(9);
      if (sel == 0) begin
        // fill the table from a fresh reset, at times past full
        push_beat(ACT_RESET, pick_net(), pick_pid(), 24'($urandom), 1'($urandom),
                  1'($urandom));
        n = $urandom_range(17, 4);
        for (int i = 0; i < n; i++)
          push_beat(ACT_ADD, pick_net(), pick_pid(), 24'($urandom), 1'($urandom),
                    1'($urandom));
      end else if (sel == 1) begin
        push_noise();
      end else begin
        push_sane_op();
      end
    end
    while (req_backlog.size() > 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else begin
      if (req.valid && req.ready) expected_results.push_back(run_table_action(beat_cur));
      if (!req.valid || req.ready) begin
        if (req_backlog.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          beat_cur = req_backlog.pop_front();
          req.valid <= 1'b1;
          req.action <= beat_cur.act;
          req.network_id <= beat_cur.net;
          req.player_id <= beat_cur.pid;
          req.red <= beat_cur.colour[23:16];
          req.green <= beat_cur.colour[15:8];
          req.blue <= beat_cur.colour[7:0];
          req.reset_all <= beat_cur.all;
          req.reset_local_id <= beat_cur.loc;
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    slot_result_t want;
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result beat with nothing pending", rsp.entry_network_id, '0);
        end else begin
          want = expected_results.pop_front();
          if (rsp.ok !== want.ok) report_mismatch("ok", 64'(rsp.ok), 64'(want.ok));
          if (rsp.slot !== want.slot) report_mismatch("slot", 64'(rsp.slot), 64'(want.slot));
          if (rsp.entry_network_id !== want.net)
            report_mismatch("entry_network_id", rsp.entry_network_id, want.net);
          if (rsp.entry_player_id !== want.pid)
            report_mismatch("entry_player_id", 64'(rsp.entry_player_id), 64'(want.pid));
          if (rsp.entry_red !== want.red)
            report_mismatch("entry_red", 64'(rsp.entry_red), 64'(want.red));
          if (rsp.entry_green !== want.green)
            report_mismatch("entry_green", 64'(rsp.entry_green), 64'(want.green));
          if (rsp.entry_blue !== want.blue)
            report_mismatch("entry_blue", 64'(rsp.entry_blue), 64'(want.blue));
        end
      end
      rsp.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("testbench failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    req.valid = 1'b0;
    req.action = ACT_RESET;
    req.network_id = '0;
    req.player_id = '0;
    req.red = '0;
    req.green = '0;
    req.blue = '0;
    req.reset_all = 1'b0;
    req.reset_local_id = 1'b0;
    rsp.ready = 1'b0;
    mismatch_count = 0;
    queued = 0;
    quiet_cycles = 0;
    src_idle_pct = 16;
    sink_idle_pct = 54;
    clear_table(1'b1, 1'b1);
    net_pool[0] = '0;
    net_pool[1] = '1;
    for (int i = 2; i < 8; i++) net_pool[i] = {$urandom, $urandom};

    push_beat(ACT_FIND_NET, '0, '0, '0, 1'b0, 1'b0);
    push_beat(ACT_ADD, '1, 16'sh8000, 24'hFFFFFF, 1'b1, 1'b1);
    push_beat(ACT_ADD, '0, 16'sh7FFF, 24'h000000, 1'b0, 1'b0);
    push_beat(ACT_ADD, 64'h0123_4567_89AB_CDEF, 16'sd1, 24'h123456, 1'b0, 1'b1);
    push_beat(ACT_ADD, 64'hFEDC_BA98_7654_3210, 16'sd2, 24'hA55AC3, 1'b1, 1'b0);
    push_beat(ACT_ALLOC, '0, '0, '0, 1'b0, 1'b0);
    push_beat(ACT_FIND_PID, '0, 16'sh8000, '0, 1'b0, 1'b0);
    push_beat(ACT_FIND_PID, '0, 16'sh7FFF, '0, 1'b0, 1'b0);
    push_beat(ACT_MARK, '1, '0, '0, 1'b0, 1'b0);
    push_beat(ACT_FIND_NET, '1, '0, '0, 1'b0, 1'b0);
    push_beat(ACT_FIND_PID, '0, 16'sh8000, '0, 1'b0, 1'b0);
    push_beat(ACT_ADD, 64'd5, 16'sd4, 24'h00FF00, 1'b0, 1'b0);
    push_beat(ACT_ALLOC, '0, '0, '0, 1'b0, 1'b0);
    push_beat(ACT_REMOVE, '0, '0, '0, 1'b0, 1'b0);
    push_beat(ACT_FIND_NET, '0, '0, '0, 1'b0, 1'b0);
    push_beat(ACT_ADD, 64'd7, 16'sd9, 24'h0000FF, 1'b0, 1'b0);
    push_beat(ACT_SET_LOCAL, '0, -16'sd2, '0, 1'b0, 1'b0);
    push_beat(ACT_FIND_PID, '0, -16'sd2, '0, 1'b0, 1'b0);
    push_beat(ACT_RESET, '0, '0, '0, 1'b0, 1'b0);
    push_beat(ACT_FIND_PID, '0, -16'sd2, '0, 1'b0, 1'b0);
    push_beat(ACT_RESET, '0, '0, '0, 1'b1, 1'b0);
    push_beat(ACT_FIND_NET, '0, '0, '0, 1'b0, 1'b0);
    push_beat(ACT_RESET, '0, '0, '0, 1'b0, 1'b1);
    push_beat(ACT_ALLOC, '0, '0, '0, 1'b0, 1'b0);
    push_beat(ACT_RESET, '0, '0, '0, 1'b1, 1'b1);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    run_phase(16, 54);
    run_phase(54, 16);
    run_phase(0, 0);

    @(posedge clk);
    while (req.valid || expected_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end
endmodule

/* filelist.f */
+incdir+src
src/pst_pkg.sv
src/pst_req_if.sv
src/pst_rsp_if.sv
src/pst_match.sv
src/pst_table.sv
src/player_slot_table_core.sv
bench/testbench.sv
